FILE: rtl/tps_pkg.sv
// Touch position smoother: shared types, widths, codes and the per-axis filter step.
// No dependencies; used by every module under rtl/.
package tps_pkg;

    localparam int FRACTION_BITS = 14;
    localparam int RAW_W         = 8;
    localparam int FILT_W        = RAW_W + FRACTION_BITS;
    localparam int SMOOTH_W      = FILT_W + 1;
    localparam int DIFF_W        = FILT_W + 2;
    localparam int TIME_W        = 64;
    localparam int INTERVAL_W    = 31;
    localparam int SHIFT_W       = 4;
    localparam int ADDR_W        = 4;
    localparam int DATA_W        = 32;

    typedef enum logic [1:0] {
        STATUS_TOUCHED        = 2'd0,
        STATUS_RELEASED       = 2'd1,
        STATUS_NOT_CONFIGURED = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ACT_IGNORED   = 2'd0,
        ACT_RESTARTED = 2'd1,
        ACT_SMOOTHED  = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        REG_MIN_INTERVAL  = 2'd0,
        REG_LONG_INTERVAL = 2'd1,
        REG_BETA_SHIFT    = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic              touched;
        logic [TIME_W-1:0] time_now;
        logic [RAW_W-1:0]  raw_x;
        logic [RAW_W-1:0]  raw_y;
    } in_item_t;

    typedef struct packed {
        status_t           status;
        action_t           sample_action;
        logic [FILT_W-1:0] filtered_x;
        logic [FILT_W-1:0] filtered_y;
    } out_item_t;

    typedef struct packed {
        logic [INTERVAL_W-1:0] min_interval_us;
        logic [INTERVAL_W-1:0] long_interval_us;
        logic [SHIFT_W-1:0]    beta_shift;
    } cfg_t;

    // One rounded exponential step toward raw; >>> gives the floor shift.
    // sh is 1..15 here (zero is filtered out as not configured).
    function automatic logic signed [SMOOTH_W-1:0] smooth_step(
        input logic signed [SMOOTH_W-1:0] cur,
        input logic [RAW_W-1:0]           raw,
        input logic [SHIFT_W-1:0]         sh
    );
        logic signed [DIFF_W-1:0] target;
        logic signed [DIFF_W-1:0] cur_ext;
        logic signed [DIFF_W-1:0] rnd;
        logic signed [DIFF_W-1:0] diff;
        logic signed [DIFF_W-1:0] sum;
        target  = signed'({2'b00, raw, {FRACTION_BITS{1'b0}}});
        cur_ext = signed'(DIFF_W'(cur));
        rnd     = signed'(DIFF_W'(1) << (sh - SHIFT_W'(1)));
        diff    = target - cur_ext + rnd;
        sum     = cur_ext + (diff >>> sh);
        return sum[SMOOTH_W-1:0];
    endfunction

endpackage

FILE: rtl/tps_csr.sv
// Touch position smoother: APB-style register file (interval and shift registers).
// Depends on tps_pkg.
module tps_csr (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [tps_pkg::ADDR_W-1:0] paddr,
    input  logic [tps_pkg::DATA_W-1:0] pwdata,
    output logic [tps_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output tps_pkg::cfg_t              cfg
);

    tps_pkg::cfg_t cfg_reg;
    logic          wr_en;
    logic [1:0]    reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                tps_pkg::REG_MIN_INTERVAL: begin
                    cfg_reg.min_interval_us <= pwdata[tps_pkg::INTERVAL_W-1:0];
                end
                tps_pkg::REG_LONG_INTERVAL: begin
                    cfg_reg.long_interval_us <= pwdata[tps_pkg::INTERVAL_W-1:0];
                end
                tps_pkg::REG_BETA_SHIFT: begin
                    cfg_reg.beta_shift <= pwdata[tps_pkg::SHIFT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            tps_pkg::REG_MIN_INTERVAL:  prdata = tps_pkg::DATA_W'(cfg_reg.min_interval_us);
            tps_pkg::REG_LONG_INTERVAL: prdata = tps_pkg::DATA_W'(cfg_reg.long_interval_us);
            tps_pkg::REG_BETA_SHIFT:    prdata = tps_pkg::DATA_W'(cfg_reg.beta_shift);
            default:                    prdata = '0;
        endcase
    end

endmodule

FILE: rtl/tps_filter.sv
// Touch position smoother: input register, filter state and step logic, result register.
// Depends on tps_pkg.
module tps_filter (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  tps_pkg::cfg_t        cfg,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  tps_pkg::in_item_t    s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output tps_pkg::out_item_t   m_data
);

    logic                                in_valid_reg;
    tps_pkg::in_item_t                   in_data_reg;
    logic                                out_valid_reg;
    tps_pkg::out_item_t                  out_data_reg;
    logic [tps_pkg::TIME_W-1:0]          last_time_reg;
    logic signed [tps_pkg::SMOOTH_W-1:0] smooth_x_reg;
    logic signed [tps_pkg::SMOOTH_W-1:0] smooth_y_reg;

    logic                                advance;
    logic                                fire;
    logic [tps_pkg::TIME_W-1:0]          elapsed;
    logic                                over_long;
    logic                                over_min;
    tps_pkg::status_t                    status_c;
    tps_pkg::action_t                    action_c;
    logic signed [tps_pkg::SMOOTH_W-1:0] smooth_x_next;
    logic signed [tps_pkg::SMOOTH_W-1:0] smooth_y_next;
    logic [tps_pkg::TIME_W-1:0]          last_time_next;

    assign advance = !out_valid_reg || m_ready;
    assign fire    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // elapsed wraps modulo 2^64; intervals are 31 bits so upper bits mean "exceeded"
    assign elapsed   = in_data_reg.time_now - last_time_reg;
    assign over_long = (|elapsed[tps_pkg::TIME_W-1:tps_pkg::INTERVAL_W]) ||
                       (elapsed[tps_pkg::INTERVAL_W-1:0] > cfg.long_interval_us);
    assign over_min  = (|elapsed[tps_pkg::TIME_W-1:tps_pkg::INTERVAL_W]) ||
                       (elapsed[tps_pkg::INTERVAL_W-1:0] > cfg.min_interval_us);

    always_comb begin
        status_c       = tps_pkg::STATUS_TOUCHED;
        action_c       = tps_pkg::ACT_IGNORED;
        smooth_x_next  = smooth_x_reg;
        smooth_y_next  = smooth_y_reg;
        last_time_next = last_time_reg;
        if (cfg.beta_shift == '0) begin
            status_c = tps_pkg::STATUS_NOT_CONFIGURED;
        end else if (!in_data_reg.touched) begin
            status_c = tps_pkg::STATUS_RELEASED;
        end else if (over_long) begin
            action_c       = tps_pkg::ACT_RESTARTED;
            last_time_next = in_data_reg.time_now;
            smooth_x_next  = signed'({1'b0, in_data_reg.raw_x,
                                      {tps_pkg::FRACTION_BITS{1'b0}}});
            smooth_y_next  = signed'({1'b0, in_data_reg.raw_y,
                                      {tps_pkg::FRACTION_BITS{1'b0}}});
        end else if (over_min) begin
            action_c       = tps_pkg::ACT_SMOOTHED;
            last_time_next = in_data_reg.time_now;
            smooth_x_next  = tps_pkg::smooth_step(smooth_x_reg, in_data_reg.raw_x,
                                                  cfg.beta_shift);
            smooth_y_next  = tps_pkg::smooth_step(smooth_y_reg, in_data_reg.raw_y,
                                                  cfg.beta_shift);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            last_time_reg <= '0;
            smooth_x_reg  <= '0;
            smooth_y_reg  <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
            if (fire) begin
                last_time_reg <= last_time_next;
                smooth_x_reg  <= smooth_x_next;
                smooth_y_reg  <= smooth_y_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
        if (fire) begin
            out_data_reg.status        <= status_c;
            out_data_reg.sample_action <= action_c;
            out_data_reg.filtered_x    <= smooth_x_next[tps_pkg::FILT_W-1:0];
            out_data_reg.filtered_y    <= smooth_y_next[tps_pkg::FILT_W-1:0];
        end
    end

    localparam logic [tps_pkg::FILT_W-1:0] FILT_MAX =
        {{tps_pkg::RAW_W{1'b1}}, {tps_pkg::FRACTION_BITS{1'b0}}};

    a_action_needs_touch: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.sample_action != tps_pkg::ACT_IGNORED) |->
            m_data.status == tps_pkg::STATUS_TOUCHED)
        else $error("filter update reported without touched status");

    a_restart_integral: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.sample_action == tps_pkg::ACT_RESTARTED) |->
            m_data.filtered_x[tps_pkg::FRACTION_BITS-1:0] == '0 &&
            m_data.filtered_y[tps_pkg::FRACTION_BITS-1:0] == '0)
        else $error("restart left fraction bits set");

    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        !smooth_x_reg[tps_pkg::SMOOTH_W-1] && !smooth_y_reg[tps_pkg::SMOOTH_W-1] &&
        smooth_x_reg[tps_pkg::FILT_W-1:0] <= FILT_MAX &&
        smooth_y_reg[tps_pkg::FILT_W-1:0] <= FILT_MAX)
        else $error("filter state out of range");

    a_time_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (!fire || action_c == tps_pkg::ACT_IGNORED) |=> $stable(last_time_reg))
        else $error("sample time changed without a filter update");

endmodule

FILE: rtl/touch_position_smoother_top.sv
// An accepted item moves from the input register to the result register behind m_valid,
// and only while that register is empty or being read. Throughput: one item per clock
// while m_ready allows; the only loop is the filter state update.
// Reset (aresetn low, synchronous): registers, filter state and sample time go to zero,
// both stages empty.
module touch_position_smoother_top (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [tps_pkg::ADDR_W-1:0] paddr,
    input  logic [tps_pkg::DATA_W-1:0] pwdata,
    output logic [tps_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  tps_pkg::in_item_t          s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output tps_pkg::out_item_t         m_data
);

    tps_pkg::cfg_t cfg;

    tps_csr u_csr (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tps_filter u_filter (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

FILE: sim/tb_touch_position_smoother_top.sv
// Testbench for touch_position_smoother_top: programs the intervals and shift over APB,
// feeds polls through valid/ready with bursts and stalls, and checks every result.
// Depends on rtl/tps_pkg.sv and rtl/touch_position_smoother_top.sv.
module tb_touch_position_smoother_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_AT_POLL = 400;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_REPORTS  = 40;

    typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_t;

    logic                       aclk    = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       psel    = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite  = 1'b0;
    logic [tps_pkg::ADDR_W-1:0] paddr   = '0;
    logic [tps_pkg::DATA_W-1:0] pwdata  = '0;
    logic [tps_pkg::DATA_W-1:0] prdata;
    logic                       pready;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    tps_pkg::in_item_t          s_data  = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    tps_pkg::out_item_t         m_data;

    touch_position_smoother_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #6 aclk = ~aclk;

    // Mirror of the register file and the filter state
    logic [tps_pkg::INTERVAL_W-1:0]      cfg_min_us   = '0;
    logic [tps_pkg::INTERVAL_W-1:0]      cfg_long_us  = '0;
    logic [tps_pkg::SHIFT_W-1:0]         cfg_shift    = '0;
    logic [tps_pkg::TIME_W-1:0]          last_poll_us = '0;
    logic signed [tps_pkg::SMOOTH_W-1:0] pos_x        = '0;
    logic signed [tps_pkg::SMOOTH_W-1:0] pos_y        = '0;

    tps_pkg::in_item_t  poll_queue[$];
    tps_pkg::out_item_t expected_results[$];

    logic                       poll_taken = 1'b0;
    logic                       hold_off   = 1'b0;
    logic [tps_pkg::TIME_W-1:0] gen_time   = '0;
    int                         gap_left   = 0;
    int                         burst_left = 1;
    int                         rx_left    = 0;
    int                         rx_tick    = 0;
    rx_mode_t                   rx_mode    = RX_ALWAYS;

    int polls_made    = 0;
    int polls_taken   = 0;
    int results_seen  = 0;
    int mismatches    = 0;
    int settings_used = 0;
    int n_restart     = 0;
    int n_smooth      = 0;
    int n_idle_touch  = 0;
    int n_released    = 0;
    int n_unconfig    = 0;

    // One rounded step toward the raw target; >>> on a signed longint floors.
    function automatic logic signed [tps_pkg::SMOOTH_W-1:0] ema_step(
        input logic signed [tps_pkg::SMOOTH_W-1:0] cur,
        input logic [tps_pkg::RAW_W-1:0]           raw,
        input logic [tps_pkg::SHIFT_W-1:0]         sh
    );
        longint goal;
        longint delta;
        goal  = longint'(raw) <<< tps_pkg::FRACTION_BITS;
        delta = goal - longint'(cur) + (longint'(1) <<< (sh - 1));
        return tps_pkg::SMOOTH_W'(longint'(cur) + (delta >>> sh));
    endfunction

    function automatic tps_pkg::out_item_t predict_poll(input tps_pkg::in_item_t poll);
        tps_pkg::out_item_t         r;
        logic [tps_pkg::TIME_W-1:0] elapsed;
        r.sample_action = tps_pkg::ACT_IGNORED;
        if (cfg_shift == '0) begin
            r.status = tps_pkg::STATUS_NOT_CONFIGURED;
        end else if (!poll.touched) begin
            r.status = tps_pkg::STATUS_RELEASED;
        end else begin
            r.status = tps_pkg::STATUS_TOUCHED;
            elapsed  = poll.time_now - last_poll_us;
            if (elapsed > tps_pkg::TIME_W'(cfg_long_us)) begin
                last_poll_us    = poll.time_now;
                pos_x           = {1'b0, poll.raw_x, {tps_pkg::FRACTION_BITS{1'b0}}};
                pos_y           = {1'b0, poll.raw_y, {tps_pkg::FRACTION_BITS{1'b0}}};
                r.sample_action = tps_pkg::ACT_RESTARTED;
            end else if (elapsed > tps_pkg::TIME_W'(cfg_min_us)) begin
                last_poll_us    = poll.time_now;
                pos_x           = ema_step(pos_x, poll.raw_x, cfg_shift);
                pos_y           = ema_step(pos_y, poll.raw_y, cfg_shift);
                r.sample_action = tps_pkg::ACT_SMOOTHED;
            end
        end
        r.filtered_x = pos_x[tps_pkg::FILT_W-1:0];
        r.filtered_y = pos_y[tps_pkg::FILT_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("[%0t] result %0d: %s", $time, results_seen, msg);
    endtask

    // Check first, then predict, so a stray result never meets this edge's poll.
    always @(posedge aclk) begin : check_and_predict
        tps_pkg::out_item_t want;
        poll_taken <= aresetn && s_valid && s_ready;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                report_mismatch("result with no poll outstanding");
            end else begin
                want = expected_results.pop_front();
                if (m_data.status !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              m_data.status, want.status));
                if (m_data.sample_action !== want.sample_action)
                    report_mismatch($sformatf("sample_action got %0d want %0d",
                                              m_data.sample_action, want.sample_action));
                if (m_data.filtered_x !== want.filtered_x)
                    report_mismatch($sformatf("filtered_x got %h want %h",
                                              m_data.filtered_x, want.filtered_x));
                if (m_data.filtered_y !== want.filtered_y)
                    report_mismatch($sformatf("filtered_y got %h want %h",
                                              m_data.filtered_y, want.filtered_y));
                case (want.sample_action)
                    tps_pkg::ACT_RESTARTED: n_restart++;
                    tps_pkg::ACT_SMOOTHED:  n_smooth++;
                    default: begin
                        if (want.status == tps_pkg::STATUS_RELEASED)
                            n_released++;
                        else if (want.status == tps_pkg::STATUS_NOT_CONFIGURED)
                            n_unconfig++;
                        else
                            n_idle_touch++;
                    end
                endcase
            end
        end
        if (aresetn && s_valid && s_ready) begin
            expected_results.push_back(predict_poll(s_data));
            polls_taken++;
        end
    end

    // Sender: bursts of random length separated by random gaps
    always @(negedge aclk) begin : drive_polls
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || poll_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (poll_queue.size() > 0) begin
                s_data  <= poll_queue.pop_front();
                s_valid <= 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: switches at random between stall patterns
    always @(negedge aclk) begin : drive_ready
        rx_tick++;
        if (rx_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = $urandom_range(16, 160);
        end else begin
            rx_left--;
        end
        if (hold_off) begin
            m_ready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_ALWAYS: m_ready <= 1'b1;
                RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: m_ready <= (rx_tick % 4 == 0);
                default:   m_ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // Long receiver hold-off mid-run so the pipeline backs up into s_ready
    initial begin : backpressure
        while (polls_taken < HOLD_AT_POLL) @(negedge aclk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge aclk);
        hold_off <= 1'b0;
    end

    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("timeout after %0d cycles, %0d results outstanding",
                 CYCLE_LIMIT, polls_made - results_seen);
        $display("*** FAILED ***");
        $finish;
    end

    task automatic write_reg(input tps_pkg::reg_idx_t idx,
                             input logic [tps_pkg::DATA_W-1:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        case (idx)
            tps_pkg::REG_MIN_INTERVAL:  cfg_min_us  = value[tps_pkg::INTERVAL_W-1:0];
            tps_pkg::REG_LONG_INTERVAL: cfg_long_us = value[tps_pkg::INTERVAL_W-1:0];
            default:                    cfg_shift   = value[tps_pkg::SHIFT_W-1:0];
        endcase
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_config(input logic [tps_pkg::DATA_W-1:0] min_v,
                              input logic [tps_pkg::DATA_W-1:0] long_v,
                              input logic [tps_pkg::DATA_W-1:0] shift_v);
        write_reg(tps_pkg::REG_MIN_INTERVAL, min_v);
        write_reg(tps_pkg::REG_LONG_INTERVAL, long_v);
        write_reg(tps_pkg::REG_BETA_SHIFT, shift_v);
        settings_used++;
        @(posedge aclk);
    endtask

    task automatic queue_poll(input logic touched, input logic [tps_pkg::TIME_W-1:0] t,
                              input logic [tps_pkg::RAW_W-1:0] x,
                              input logic [tps_pkg::RAW_W-1:0] y);
        tps_pkg::in_item_t p;
        p.touched  = touched;
        p.time_now = t;
        p.raw_x    = x;
        p.raw_y    = y;
        poll_queue.push_back(p);
        polls_made++;
    endtask

    function automatic logic [tps_pkg::RAW_W-1:0] pick_raw();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return '0;
        else if (pick == 1)
            return '1;
        return tps_pkg::RAW_W'($urandom);
    endfunction

    // Time steps aimed at each side of both interval thresholds, plus wild jumps
    task automatic queue_random_polls(input int count);
        logic [tps_pkg::TIME_W-1:0] step;
        int unsigned                pick;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < 10)
                step = tps_pkg::TIME_W'($urandom_range(0, cfg_min_us));
            else if (pick < 15)
                step = tps_pkg::TIME_W'(cfg_min_us);
            else if (pick < 55 && cfg_long_us > cfg_min_us)
                step = tps_pkg::TIME_W'($urandom_range(cfg_min_us + 1, cfg_long_us));
            else if (pick < 60)
                step = tps_pkg::TIME_W'(cfg_long_us);
            else if (pick < 85)
                step = tps_pkg::TIME_W'(cfg_long_us) +
                       tps_pkg::TIME_W'($urandom_range(1, 5000));
            else if (pick < 93)
                step = {$urandom, $urandom};
            else
                step = -tps_pkg::TIME_W'($urandom_range(1, 100));
            gen_time += step;
            queue_poll($urandom_range(0, 99) < 85, gen_time, pick_raw(), pick_raw());
        end
    endtask

    task automatic wait_idle();
        while (results_seen < polls_made) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    initial begin : stimulus
        logic [tps_pkg::TIME_W-1:0] t;
        logic [tps_pkg::DATA_W-1:0] min_v;
        logic [tps_pkg::DATA_W-1:0] long_v;
        logic [tps_pkg::DATA_W-1:0] shift_v;
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Out of reset the shift is zero: everything reports not configured
        queue_poll(1'b1, '1, '1, '1);
        queue_poll(1'b0, '0, '0, '0);
        queue_poll(1'b1, 64'h8000_0000_0000_0000, 8'h00, 8'hFF);
        wait_idle();

        set_config(32'd100, 32'd5000, 32'd4);
        queue_poll(1'b0, 64'd0, 8'h00, 8'hFF);
        queue_poll(1'b1, 64'd0, 8'h00, 8'h00);          // zero elapsed
        queue_poll(1'b1, 64'd10000, 8'hFF, 8'h00);      // past long interval
        queue_poll(1'b1, 64'd10050, 8'h00, 8'hFF);      // inside min interval
        queue_poll(1'b1, 64'd10200, 8'h00, 8'hFF);
        queue_poll(1'b1, 64'd10300, 8'd17, 8'd200);     // exactly min: no step
        queue_poll(1'b1, 64'd10301, 8'd17, 8'd200);
        queue_poll(1'b1, 64'd15301, 8'hFF, 8'hFF);      // exactly long: smooths
        queue_poll(1'b1, 64'd20302, 8'd128, 8'd64);
        queue_poll(1'b1, 64'hFFFF_FFFF_FFFF_FFF0, 8'd1, 8'd254);
        queue_poll(1'b1, 64'd5, 8'd200, 8'd3);          // timer wrapped, short gap
        queue_poll(1'b1, 64'd300, 8'd200, 8'd3);
        queue_poll(1'b0, '1, 8'hFF, 8'hFF);             // release holds the filter
        wait_idle();

        // Upper bits of the write data must be dropped
        set_config(32'd0, 32'hFFFF_FFFF, 32'd15);
        t = 64'd300;
        queue_poll(1'b1, t, 8'h00, 8'hFF);
        queue_poll(1'b1, t + 1, 8'h00, 8'hFF);
        queue_poll(1'b1, t + 2, 8'hFF, 8'h00);
        t = t + 2 + 64'h8000_0000;
        queue_poll(1'b1, t, 8'hFF, 8'h00);              // one past the longest interval
        wait_idle();

        set_config(32'd0, 32'h7FFF_FFFF, 32'd1);
        queue_poll(1'b1, t + 1, 8'h00, 8'h00);
        queue_poll(1'b1, t + 2, 8'hFF, 8'hFF);
        wait_idle();

        set_config(32'd0, 32'd0, 32'd1);
        queue_poll(1'b1, t + 2, 8'd77, 8'd99);
        queue_poll(1'b1, t + 3, 8'd77, 8'd99);
        wait_idle();

        set_config(32'd50, 32'd60, 32'd0);
        queue_poll(1'b1, t + 100, 8'hFF, 8'h00);
        queue_poll(1'b0, t + 200, 8'h00, 8'hFF);
        wait_idle();

        gen_time = {$urandom, $urandom};
        for (int p = 0; p < 8; p++) begin
            min_v   = $urandom_range(0, 200);
            long_v  = min_v + $urandom_range(1, 20000);
            shift_v = $urandom_range(1, 15);
            case (p)
                0: begin
                    min_v   = 32'd10;
                    long_v  = 32'd1000;
                    shift_v = 32'd3;
                end
                1: begin
                    min_v   = 32'd0;
                    long_v  = 32'hFFFF_FFFF;
                    shift_v = 32'hFFFF_FFFF;
                end
                2: shift_v = 32'd1;
                4: begin
                    min_v  = 32'hFFFF_FFFF;
                    long_v = 32'hFFFF_FFFF;
                end
                6: begin
                    min_v  = 32'd5;
                    long_v = 32'd5;
                end
                7: shift_v = 32'd0;
                default: ;
            endcase
            set_config(min_v, long_v, shift_v);
            queue_random_polls((p == 7) ? 40 : 190);
            wait_idle();
        end

        $display("Checked %0d results from %0d polls under %0d register settings.",
                 results_seen, polls_made, settings_used);
        $display("Restarts %0d, smoothing steps %0d, idle touches %0d, releases %0d, %s%0d.",
                 n_restart, n_smooth, n_idle_touch, n_released, "unconfigured ", n_unconfig);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/tps_pkg.sv
rtl/tps_csr.sv
rtl/tps_filter.sv
rtl/touch_position_smoother_top.sv
sim/tb_touch_position_smoother_top.sv
